// ===== rtl/lnc_pkg.sv =====
// Shared types, event codes, register indexes and constants for the noise channel.
package lnc_pkg;

   // Field widths
   localparam int FUNC_W     = 3;
   localparam int LENGTH_W   = 7;
   localparam int LEVEL_W    = 4;
   localparam int PERIOD_W   = 20;
   localparam int LFSR_W     = 15;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   // Default full length of the length counter
   localparam int LNC_LENGTH_FULL = 64;

   // Event codes carried by an item
   localparam logic [FUNC_W-1:0] FUNC_TICK     = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_LEN_CLK  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_ENV_CLK  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_TRIGGER  = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_LEN_LOAD = 3'd4;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DIVIDER_CODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SHIFT_AMOUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SHORT_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ENV_PACE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ENV_UP       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_START_VOLUME = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_LENGTH_ON    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_DAC_ON       = 3'd7;

   // LFSR and volume constants
   localparam logic [LFSR_W-1:0]  LFSR_ALL_ONES = 15'h7FFF;
   localparam logic [3:0]         FREEZE_SHIFT  = 4'd14;
   localparam logic [LEVEL_W-1:0] MAX_VOLUME    = 4'd15;
   localparam int                 SHORT_TAP     = 6;

   // Configuration register file contents
   typedef struct packed {
      logic [2:0]         divider_code;
      logic [3:0]         shift_amount;
      logic               short_width;
      logic [2:0]         env_pace;
      logic               env_up;
      logic [LEVEL_W-1:0] start_volume;
      logic               length_on;
      logic               dac_on;
   } lnc_cfg_type;

   // One result item
   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic               active;
   } lnc_rsp_type;

endpackage

// ===== rtl/lnc_csr.sv =====
// Configuration register file of the noise channel.
module lnc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic [lnc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lnc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output lnc_pkg::lnc_cfg_type            cfg
);
   import lnc_pkg::*;

   lnc_cfg_type cfg_ff;
   lnc_cfg_type cfg_in;

   // Decode the written register and keep the rest.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_DIVIDER_CODE: cfg_in.divider_code = csr_wdata[2:0];
            REG_SHIFT_AMOUNT: cfg_in.shift_amount = csr_wdata[3:0];
            REG_SHORT_WIDTH:  cfg_in.short_width  = csr_wdata[0];
            REG_ENV_PACE:     cfg_in.env_pace     = csr_wdata[2:0];
            REG_ENV_UP:       cfg_in.env_up       = csr_wdata[0];
            REG_START_VOLUME: cfg_in.start_volume = csr_wdata[3:0];
            REG_LENGTH_ON:    cfg_in.length_on    = csr_wdata[0];
            REG_DAC_ON:       cfg_in.dac_on       = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/lnc_engine.sv =====
// Channel state and the single-pass next-state logic for one event item.
module lnc_engine #(
   parameter int LENGTH_FULL = lnc_pkg::LNC_LENGTH_FULL
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           accept,
   input  logic [lnc_pkg::FUNC_W-1:0]     func,
   input  logic [lnc_pkg::LENGTH_W-1:0]   length_value,
   input  lnc_pkg::lnc_cfg_type           cfg,
   output lnc_pkg::lnc_rsp_type           rsp
);
   import lnc_pkg::*;

   localparam logic [LENGTH_W-1:0] LEN_FULL = LENGTH_W'(LENGTH_FULL);

   logic [LFSR_W-1:0]   shift_reg_ff, shift_reg_in;
   logic [PERIOD_W-1:0] period_left_ff, period_left_in;
   logic [LENGTH_W-1:0] length_left_ff, length_left_in;
   logic [2:0]          env_count_ff, env_count_in;
   logic [LEVEL_W-1:0]  volume_now_ff, volume_now_in;
   logic                enabled_ff, enabled_in;
   logic [LEVEL_W-1:0]  out_level_ff, out_level_in;

   logic [6:0]          divisor;
   logic [PERIOD_W+1:0] shifted;
   logic [PERIOD_W-1:0] reload;

   // Timer reload value: divisor shifted left, then divided by four.
   always_comb begin
      divisor = (cfg.divider_code == 3'd0) ? 7'd8 : {cfg.divider_code, 4'b0000};
      shifted = (PERIOD_W+2)'(divisor) << cfg.shift_amount;
      reload  = shifted[PERIOD_W+1:2];
   end

   // Next state for the item at the input.
   always_comb begin
      logic [PERIOD_W-1:0] period_dec;
      logic                fb;
      logic [LFSR_W-1:0]   lfsr_next;

      shift_reg_in   = shift_reg_ff;
      period_left_in = period_left_ff;
      length_left_in = length_left_ff;
      env_count_in   = env_count_ff;
      volume_now_in  = volume_now_ff;
      enabled_in     = enabled_ff;
      out_level_in   = out_level_ff;
      period_dec     = (period_left_ff != '0) ? period_left_ff - 1'b1 : period_left_ff;
      fb             = shift_reg_ff[0] ^ shift_reg_ff[1];
      lfsr_next      = {fb, shift_reg_ff[LFSR_W-1:1]};
      if (cfg.short_width) begin
         lfsr_next[SHORT_TAP] = fb;
      end

      unique case (func)
         FUNC_TICK: begin
            out_level_in = '0;
            if (enabled_ff && cfg.dac_on && (cfg.shift_amount < FREEZE_SHIFT)) begin
               if (period_dec == '0) begin
                  period_left_in = reload;
                  shift_reg_in   = lfsr_next;
               end else begin
                  period_left_in = period_dec;
               end
               if (!shift_reg_in[0]) begin
                  out_level_in = volume_now_ff;
               end
            end
         end
         FUNC_LEN_CLK: begin
            if (cfg.length_on && (length_left_ff != '0)) begin
               length_left_in = length_left_ff - 1'b1;
               if (length_left_ff == LENGTH_W'(1)) begin
                  enabled_in = 1'b0;
               end
            end
         end
         FUNC_ENV_CLK: begin
            if (cfg.env_pace != 3'd0) begin
               if (env_count_ff > 3'd1) begin
                  env_count_in = env_count_ff - 1'b1;
               end else begin
                  env_count_in = cfg.env_pace;
                  if (cfg.env_up && (volume_now_ff != MAX_VOLUME)) begin
                     volume_now_in = volume_now_ff + 1'b1;
                  end else if (!cfg.env_up && (volume_now_ff != '0)) begin
                     volume_now_in = volume_now_ff - 1'b1;
                  end
               end
            end
         end
         FUNC_TRIGGER: begin
            enabled_in     = cfg.dac_on;
            length_left_in = (length_left_ff == '0) ? LEN_FULL : length_left_ff;
            shift_reg_in   = LFSR_ALL_ONES;
            env_count_in   = cfg.env_pace;
            volume_now_in  = cfg.start_volume;
            period_left_in = reload;
         end
         FUNC_LEN_LOAD: begin
            length_left_in = (length_value > LEN_FULL) ? LEN_FULL : length_value;
         end
         default: begin
            out_level_in = out_level_ff;
         end
      endcase
   end

   // State moves only when an item is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_reg_ff   <= LFSR_ALL_ONES;
         period_left_ff <= '0;
         length_left_ff <= '0;
         env_count_ff   <= '0;
         volume_now_ff  <= '0;
         enabled_ff     <= 1'b0;
         out_level_ff   <= '0;
      end else if (accept) begin
         shift_reg_ff   <= shift_reg_in;
         period_left_ff <= period_left_in;
         length_left_ff <= length_left_in;
         env_count_ff   <= env_count_in;
         volume_now_ff  <= volume_now_in;
         enabled_ff     <= enabled_in;
         out_level_ff   <= out_level_in;
      end
   end

   // The result reflects the state after the item.
   assign rsp.level  = out_level_in;
   assign rsp.active = enabled_in;

`ifndef SYNTHESIS
   // A trigger with the converter off leaves the channel disabled.
   a_trig_dac_off: assert property (@(posedge clock) disable iff (reset)
      accept && (func == FUNC_TRIGGER) && !cfg.dac_on |=> !enabled_ff)
      else $error("trigger with converter off enabled the channel");

   // A tick with the converter off forces the held level to zero.
   a_tick_dac_off: assert property (@(posedge clock) disable iff (reset)
      accept && (func == FUNC_TICK) && !cfg.dac_on |=> (out_level_ff == '0))
      else $error("tick with converter off left a nonzero level");

   // The length counter never exceeds its full value.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      length_left_ff <= LEN_FULL)
      else $error("length counter above full value");
`endif

endmodule

// ===== rtl/lnc_out_buf.sv =====
// Two-entry result buffer: output register plus a skid register.
module lnc_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  lnc_pkg::lnc_rsp_type  push_data,
   output logic                  full,
   output logic                  out_valid,
   input  logic                  out_stall,
   output lnc_pkg::lnc_rsp_type  out_data
);
   import lnc_pkg::*;

   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   lnc_rsp_type out_data_ff, out_data_in;
   lnc_rsp_type skid_data_ff, skid_data_in;
   logic        pop;

   assign pop = out_valid_ff && !out_stall;

   // Refill the output from the skid stage first, else from the new item.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         out_valid_in  = skid_valid_ff || push;
         out_data_in   = skid_valid_ff ? skid_data_ff : push_data;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

`ifndef SYNTHESIS
   // The skid entry is only ever used behind a valid output entry.
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // After a push the output entry is always valid on the next cycle.
   a_push_visible: assert property (@(posedge clock) disable iff (reset)
      push |=> out_valid_ff)
      else $error("pushed item did not reach the output");

   // No push is taken while both entries are occupied.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !push)
      else $error("push into a full result buffer");
`endif

endmodule

// ===== rtl/lfsr_noise_channel_core.sv =====
// Top level of the LFSR noise channel: ports, configuration, engine and result buffer.
//
// Usage:
//   Each item on the req_ channel is one event (tick, length clock, envelope
//   clock, trigger or length load) with a length value used by the load.
//   Every accepted item produces exactly one result item on the rsp_ channel,
//   carrying the held output level and the channel enable flag after the event.
//   Configuration registers are written on the csr_ channel, which is always
//   ready; write them only while no items are in flight.
// Latency and throughput:
//   The engine updates its state in the cycle an item is accepted; the result is
//   valid in the next cycle unless the output register holds a stalled result.
//   This sets the rate: one item per cycle is accepted when the receiver keeps up.
// Stalls:
//   A two-entry result buffer sits at the output. When rsp_stall is held the
//   buffer fills and req_stall rises after one more item; req_stall is driven
//   from a register only.
// Reset:
//   Synchronous, active high. Channel and configuration registers clear to zero,
//   the LFSR to all ones, and the result buffer empties.
module lfsr_noise_channel_core #(
   parameter int LENGTH_FULL = lnc_pkg::LNC_LENGTH_FULL
) (
   input  logic                            clock,
   input  logic                            reset,
   // Event items
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [lnc_pkg::FUNC_W-1:0]      req_func,
   input  logic [lnc_pkg::LENGTH_W-1:0]    req_length_value,
   // Result items
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lnc_pkg::LEVEL_W-1:0]     rsp_level,
   output logic                            rsp_active,
   // Configuration writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lnc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lnc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import lnc_pkg::*;

   lnc_cfg_type cfg;
   lnc_rsp_type eng_rsp;
   lnc_rsp_type buf_rsp;
   logic        accept;
   logic        buf_full;

   assign csr_ready = 1'b1;
   assign req_stall = buf_full;
   assign accept    = req_valid && !buf_full;

   // Configuration registers
   lnc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Channel state and event processing
   lnc_engine #(
      .LENGTH_FULL (LENGTH_FULL)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .func         (req_func),
      .length_value (req_length_value),
      .cfg          (cfg),
      .rsp          (eng_rsp)
   );

   // Result buffer
   lnc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (eng_rsp),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (buf_rsp)
   );

   assign rsp_level  = buf_rsp.level;
   assign rsp_active = buf_rsp.active;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the LFSR noise channel core.
module tb_top;
   import lnc_pkg::*;

   // Unused event codes; the block must leave its state alone on these.
   localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST  = 3'd7;

   localparam int SETTLE_CYCLES  = 4;
   localparam int STUCK_LIMIT    = 2000;
   localparam int RANDOM_PHASES  = 19;
   localparam int PHASE_ITEMS    = 100;

   logic                    clock;
   logic                    reset            = 1'b1;
   logic                    req_valid        = 1'b0;
   logic                    req_stall;
   logic [FUNC_W-1:0]       req_func         = '0;
   logic [LENGTH_W-1:0]     req_length_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall        = 1'b0;
   logic [LEVEL_W-1:0]      rsp_level;
   logic                    rsp_active;
   logic                    csr_valid        = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index        = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata        = '0;

   // Mirror of the channel state and its registers.
   lnc_cfg_type             chan_cfg;
   logic [LFSR_W-1:0]       noise_lfsr;
   logic [PERIOD_W-1:0]     period_count;
   logic [LENGTH_W-1:0]     length_count;
   logic [2:0]              env_count;
   logic [LEVEL_W-1:0]      volume;
   logic                    channel_on;
   logic [LEVEL_W-1:0]      held_level;

   lnc_rsp_type             predicted_out_q[$];
   int unsigned             fail_count  = 0;
   int unsigned             stuck_cycles = 0;
   int unsigned             stall_hold  = 0;
   bit                      no_gaps     = 1'b0;
   lnc_cfg_type             settings;

   lfsr_noise_channel_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_length_value (req_length_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_level        (rsp_level),
      .rsp_active       (rsp_active),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one, none in steady stretches.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (no_gaps) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Timer reload value for the current divider and shift.
   function automatic logic [PERIOD_W-1:0] period_reload();
      logic [31:0] divisor;
      divisor = (chan_cfg.divider_code == 3'd0) ? 32'd8 :
                32'({chan_cfg.divider_code, 4'b0000});
      return PERIOD_W'((divisor << chan_cfg.shift_amount) >> 2);
   endfunction

   // Apply one event to the mirrored state and return the level and enable flag.
   task automatic advance_channel(input logic [FUNC_W-1:0] func,
                                  input logic [LENGTH_W-1:0] length_value,
                                  output lnc_rsp_type outcome);
      logic feedback;
      case (func)
         FUNC_TICK: begin
            held_level = '0;
            if (channel_on && chan_cfg.dac_on && chan_cfg.shift_amount < FREEZE_SHIFT) begin
               if (period_count != '0) period_count = period_count - 1'b1;
               if (period_count == '0) begin
                  feedback     = noise_lfsr[0] ^ noise_lfsr[1];
                  period_count = period_reload();
                  noise_lfsr   = {feedback, noise_lfsr[LFSR_W-1:1]};
                  if (chan_cfg.short_width) noise_lfsr[SHORT_TAP] = feedback;
               end
               if (!noise_lfsr[0]) held_level = volume;
            end
         end
         FUNC_LEN_CLK: begin
            if (chan_cfg.length_on && length_count != '0) begin
               length_count = length_count - 1'b1;
               if (length_count == '0) channel_on = 1'b0;
            end
         end
         FUNC_ENV_CLK: begin
            if (chan_cfg.env_pace != '0) begin
               if (env_count != '0) env_count = env_count - 1'b1;
               if (env_count == '0) begin
                  env_count = chan_cfg.env_pace;
                  if (chan_cfg.env_up && volume < MAX_VOLUME) volume = volume + 1'b1;
                  else if (!chan_cfg.env_up && volume != '0) volume = volume - 1'b1;
               end
            end
         end
         FUNC_TRIGGER: begin
            channel_on = chan_cfg.dac_on;
            if (length_count == '0) length_count = LENGTH_W'(LNC_LENGTH_FULL);
            noise_lfsr   = LFSR_ALL_ONES;
            env_count    = chan_cfg.env_pace;
            volume       = chan_cfg.start_volume;
            period_count = period_reload();
         end
         FUNC_LEN_LOAD: begin
            length_count = (length_value > LNC_LENGTH_FULL) ?
                           LENGTH_W'(LNC_LENGTH_FULL) : length_value;
         end
         default: ;
      endcase
      outcome.level  = held_level;
      outcome.active = channel_on;
   endtask

   // Predict on each accepted item, track register writes and check each result.
   always @(posedge clock) begin
      lnc_rsp_type want;
      if (reset) begin
         chan_cfg     = '0;
         noise_lfsr   = LFSR_ALL_ONES;
         period_count = '0;
         length_count = '0;
         env_count    = '0;
         volume       = '0;
         channel_on   = 1'b0;
         held_level   = '0;
         predicted_out_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DIVIDER_CODE: chan_cfg.divider_code = csr_wdata[2:0];
               REG_SHIFT_AMOUNT: chan_cfg.shift_amount = csr_wdata[3:0];
               REG_SHORT_WIDTH:  chan_cfg.short_width  = csr_wdata[0];
               REG_ENV_PACE:     chan_cfg.env_pace     = csr_wdata[2:0];
               REG_ENV_UP:       chan_cfg.env_up       = csr_wdata[0];
               REG_START_VOLUME: chan_cfg.start_volume = csr_wdata[3:0];
               REG_LENGTH_ON:    chan_cfg.length_on    = csr_wdata[0];
               REG_DAC_ON:       chan_cfg.dac_on       = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            advance_channel(req_func, req_length_value, want);
            predicted_out_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_out_q.size() == 0) begin
               $display("%0t: unexpected result, level %0d active %0d",
                        $time, rsp_level, rsp_active);
               fail_count++;
            end else begin
               want = predicted_out_q.pop_front();
               if (rsp_level !== want.level) begin
                  $display("%0t: level expected %0d, actual %0d", $time, want.level, rsp_level);
                  fail_count++;
               end
               if (rsp_active !== want.active) begin
                  $display("%0t: active expected %0d, actual %0d",
                           $time, want.active, rsp_active);
                  fail_count++;
               end
            end
         end
      end
   end

   // Receiver stalls of random length.
   always @(posedge clock) begin
      int unsigned span;
      if (reset || no_gaps) begin
         rsp_stall <= 1'b0;
         stall_hold = 0;
      end else if (stall_hold != 0) begin
         stall_hold = stall_hold - 1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         stall_hold = $urandom_range(0, 5);
      end else begin
         span = pick_gap();
         if (span != 0) begin
            rsp_stall <= 1'b1;
            stall_hold = span - 1;
         end
      end
   end

   // Watchdog: end the run when no handshake completes for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STUCK_LIMIT);
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   // Send one item and hold it until accepted, then maybe leave a gap.
   task automatic send_event(input logic [FUNC_W-1:0] func,
                             input logic [LENGTH_W-1:0] length_value);
      int unsigned gap;
      req_valid        <= 1'b1;
      req_func         <= func;
      req_length_value <= length_value;
      do @(posedge clock); while (req_stall);
      gap = pick_gap();
      if (gap != 0) begin
         req_valid        <= 1'b0;
         req_func         <= FUNC_W'($urandom_range(0, 7));
         req_length_value <= LENGTH_W'($urandom_range(0, 127));
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every predicted result has come back.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_out_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all eight registers while the channel is idle; junk in unused bits.
   task automatic apply_settings(input lnc_cfg_type cfg);
      logic [CSR_DATA_W-1:0] value;
      logic [CSR_DATA_W-1:0] keep_mask;
      wait_until_drained();
      for (int i = 0; i <= REG_DAC_ON; i++) begin
         case (CSR_IDX_W'(i))
            REG_DIVIDER_CODE: begin
               value = CSR_DATA_W'(cfg.divider_code); keep_mask = 8'h07;
            end
            REG_SHIFT_AMOUNT: begin
               value = CSR_DATA_W'(cfg.shift_amount); keep_mask = 8'h0F;
            end
            REG_SHORT_WIDTH: begin
               value = CSR_DATA_W'(cfg.short_width); keep_mask = 8'h01;
            end
            REG_ENV_PACE: begin
               value = CSR_DATA_W'(cfg.env_pace); keep_mask = 8'h07;
            end
            REG_ENV_UP: begin
               value = CSR_DATA_W'(cfg.env_up); keep_mask = 8'h01;
            end
            REG_START_VOLUME: begin
               value = CSR_DATA_W'(cfg.start_volume); keep_mask = 8'h0F;
            end
            REG_LENGTH_ON: begin
               value = CSR_DATA_W'(cfg.length_on); keep_mask = 8'h01;
            end
            default: begin
               value = CSR_DATA_W'(cfg.dac_on); keep_mask = 8'h01;
            end
         endcase
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= value | (CSR_DATA_W'($urandom_range(0, 255)) & ~keep_mask);
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // Defaults after reset: converter off, so a trigger must not enable.
   task automatic test_reset_defaults();
      send_event(FUNC_TICK, '0);
      send_event(FUNC_TRIGGER, '0);
      send_event(FUNC_SPARE_FIRST, 7'h7F);
      send_event(FUNC_SPARE_LAST, 7'h2A);
      send_event(FUNC_LEN_LOAD, 7'h7F);
   endtask

   // Trigger with the shortest period and the short sequence, then run the LFSR.
   task automatic test_trigger_and_noise();
      settings              = '0;
      settings.dac_on       = 1'b1;
      settings.start_volume = MAX_VOLUME;
      settings.short_width  = 1'b1;
      apply_settings(settings);
      send_event(FUNC_TRIGGER, '0);
      repeat (8) send_event(FUNC_TICK, '0);
   endtask

   // Length loads saturate, a trigger fills an empty counter, expiry disables.
   task automatic test_length_counter();
      settings.length_on = 1'b1;
      apply_settings(settings);
      send_event(FUNC_LEN_LOAD, 7'h7F);
      send_event(FUNC_LEN_LOAD, 7'd0);
      send_event(FUNC_TRIGGER, '0);
      send_event(FUNC_LEN_LOAD, 7'd2);
      send_event(FUNC_LEN_CLK, '0);
      send_event(FUNC_LEN_CLK, '0);
      send_event(FUNC_TICK, '0);
   endtask

   // Envelope steps up and saturates at full volume; a large shift freezes the LFSR.
   task automatic test_envelope_and_freeze();
      settings.length_on    = 1'b0;
      settings.env_pace     = 3'd1;
      settings.env_up       = 1'b1;
      settings.start_volume = 4'd14;
      settings.shift_amount = 4'd15;
      apply_settings(settings);
      send_event(FUNC_TRIGGER, '0);
      send_event(FUNC_ENV_CLK, '0);
      send_event(FUNC_ENV_CLK, '0);
      send_event(FUNC_TICK, '0);
   endtask

   // Phases of random events, each under its own register settings.
   task automatic test_random_settings();
      int unsigned roll;
      logic [FUNC_W-1:0] func;
      logic [LENGTH_W-1:0] length_value;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settings.divider_code = 3'($urandom_range(0, 7));
         roll = $urandom_range(0, 99);
         if (roll < 80) settings.shift_amount = 4'($urandom_range(0, 2));
         else if (roll < 90) settings.shift_amount = 4'($urandom_range(3, 8));
         else settings.shift_amount = 4'($urandom_range(14, 15));
         settings.short_width  = 1'($urandom_range(0, 1));
         settings.env_pace     = 3'($urandom_range(0, 7));
         settings.env_up       = 1'($urandom_range(0, 1));
         settings.start_volume = 4'($urandom_range(0, 15));
         settings.length_on    = 1'($urandom_range(0, 1));
         settings.dac_on       = ($urandom_range(0, 9) != 0);
         // The first phases pin the extremes.
         if (phase == 0) begin
            settings = '0;
         end else if (phase == 1) begin
            settings = '1;
         end else if (phase == 2) begin
            settings.divider_code = 3'd7;
            settings.shift_amount = 4'd13;
            settings.dac_on       = 1'b1;
         end
         apply_settings(settings);
         no_gaps = (phase == 3);
         send_event(FUNC_TRIGGER, LENGTH_W'($urandom_range(0, 127)));
         for (int n = 1; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            length_value = LENGTH_W'($urandom_range(0, 127));
            if (roll < 8) func = FUNC_TRIGGER;
            else if (roll < 58) func = FUNC_TICK;
            else if (roll < 68) func = FUNC_LEN_CLK;
            else if (roll < 78) func = FUNC_ENV_CLK;
            else if (roll < 93) func = FUNC_LEN_LOAD;
            else func = FUNC_W'($urandom_range(FUNC_SPARE_FIRST, FUNC_SPARE_LAST));
            // Loads favor short lengths so the counter runs out often.
            if (func == FUNC_LEN_LOAD) begin
               roll = $urandom_range(0, 99);
               if (roll < 50) length_value = LENGTH_W'($urandom_range(1, 6));
               else if (roll < 85) length_value = LENGTH_W'($urandom_range(0, 64));
               else length_value = LENGTH_W'($urandom_range(65, 127));
            end
            send_event(func, length_value);
         end
         no_gaps = 1'b0;
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_trigger_and_noise();
      test_length_counter();
      test_envelope_and_freeze();
      test_random_settings();
      wait_until_drained();
      if (fail_count == 0 && predicted_out_q.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// ===== lfsr_noise_channel_core.f =====
rtl/lnc_pkg.sv
rtl/lnc_csr.sv
rtl/lnc_engine.sv
rtl/lnc_out_buf.sv
rtl/lfsr_noise_channel_core.sv
tb/tb_top.sv
